@@ rtl/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// shared constants and types for the fifo queue with search: sizes,
// command and status codes, and the control word that drives the cell chain
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_SHOW    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_VALUE     = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROTATE,
        CELL_SEARCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t                      op;
        logic signed [DATA_WIDTH-1:0] value;
    } cell_ctrl_t;

endpackage

@@ rtl/fqs_cell.sv @@
// ----------------------------------------------------------------------------
// fqs_cell
// one queue slot: holds a word and its valid bit, loads from its upper
// neighbor on pop and rotate, and compares against the search word
// ----------------------------------------------------------------------------
module fqs_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fqs_pkg::cell_ctrl_t                  ctrl,
    input  logic                                 prev_valid,
    input  logic                                 next_valid,
    input  logic signed [fqs_pkg::DATA_WIDTH-1:0] next_data,
    input  logic signed [fqs_pkg::DATA_WIDTH-1:0] head_data,
    output logic                                 valid,
    output logic signed [fqs_pkg::DATA_WIDTH-1:0] data,
    output logic                                 hit
);

    logic                                 valid_reg;
    logic signed [fqs_pkg::DATA_WIDTH-1:0] data_reg;
    logic                                 hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            case (ctrl.op)
                fqs_pkg::CELL_PUSH: begin
                    // first free slot above the occupied run takes the word
                    if (!valid_reg && prev_valid) begin
                        valid_reg <= 1'b1;
                    end
                end
                fqs_pkg::CELL_POP: begin
                    valid_reg <= next_valid;
                end
                fqs_pkg::CELL_SEARCH: begin
                    hit_reg <= valid_reg && (data_reg == ctrl.value);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            fqs_pkg::CELL_PUSH: begin
                if (!valid_reg && prev_valid) begin
                    data_reg <= ctrl.value;
                end
            end
            fqs_pkg::CELL_POP: begin
                data_reg <= next_data;
            end
            fqs_pkg::CELL_ROTATE: begin
                // the top occupied cell wraps the head word around
                if (next_valid) begin
                    data_reg <= next_data;
                end else if (valid_reg) begin
                    data_reg <= head_data;
                end
            end
            default: begin
            end
        endcase
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign hit   = hit_reg;

endmodule

@@ rtl/fifo_queue_with_search_core.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// bounded fifo of signed words built as a chain of cells, with search and show
// ----------------------------------------------------------------------------
// The queue is a row of cells with the oldest word always in the first cell.
// Enqueue and dequeue can follow each other back to back while the result
// register drains. In a search every cell compares its word in the accept
// cycle and the hit bits are combined in the next. Show emits the head word
// and rotates the chain by one cell each time the result register is free,
// once per stored word; after a full pass the order is back as it was.
// A new transaction is taken only once the previous search or show has
// delivered its final result. Show on an empty queue and dequeue on an empty
// queue give one empty result with data all ones; enqueue on a full queue
// drops the word and gives a full result.
module fifo_queue_with_search_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic signed [fqs_pkg::DATA_WIDTH-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_status,
    output logic signed [fqs_pkg::DATA_WIDTH-1:0] m_data,
    output logic                                 m_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHOW
    } state_t;

    localparam int DEPTH = fqs_pkg::QUEUE_DEPTH;
    localparam int DW    = fqs_pkg::DATA_WIDTH;

    state_t                         state_reg;
    logic                           m_valid_reg;
    fqs_pkg::status_t               m_status_reg;
    logic signed [DW-1:0]           m_data_reg;
    logic                           m_last_reg;
    logic [fqs_pkg::OCC_W-1:0]      occ_reg;
    logic [fqs_pkg::CNT_W-1:0]      cnt_reg;
    logic [fqs_pkg::OCC_W-1:0]      occ_less_one;

    fqs_pkg::cell_ctrl_t            ctrl;
    fqs_pkg::cmd_t                  cmd;
    logic [DEPTH-1:0]               valid_bus;
    logic [DEPTH-1:0]               hit_bus;
    logic signed [DW-1:0]           data_bus [DEPTH];

    logic out_free;
    logic accept;
    logic full;
    logic empty;

    assign cmd      = fqs_pkg::cmd_t'(s_command);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = valid_bus[DEPTH-1];
    assign empty    = !valid_bus[0];
    assign occ_less_one = occ_reg - fqs_pkg::OCC_W'(1);

    always_comb begin
        ctrl.op    = fqs_pkg::CELL_HOLD;
        ctrl.value = s_value;
        if (accept) begin
            case (cmd)
                fqs_pkg::CMD_ENQUEUE: if (!full)  ctrl.op = fqs_pkg::CELL_PUSH;
                fqs_pkg::CMD_DEQUEUE: if (!empty) ctrl.op = fqs_pkg::CELL_POP;
                fqs_pkg::CMD_SEARCH:  ctrl.op = fqs_pkg::CELL_SEARCH;
                default:              ctrl.op = fqs_pkg::CELL_HOLD;
            endcase
        end else if (state_reg == S_SHOW && out_free) begin
            ctrl.op = fqs_pkg::CELL_ROTATE;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 prev_v;
        logic                 next_v;
        logic signed [DW-1:0] next_d;

        if (i == 0) begin : g_first
            assign prev_v = 1'b1;
        end else begin : g_mid
            assign prev_v = valid_bus[i-1];
        end

        if (i == DEPTH - 1) begin : g_top
            assign next_v = 1'b0;
            assign next_d = '0;
        end else begin : g_below
            assign next_v = valid_bus[i+1];
            assign next_d = data_bus[i+1];
        end

        fqs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_data  (next_d),
            .head_data  (data_bus[0]),
            .valid      (valid_bus[i]),
            .data       (data_bus[i]),
            .hit        (hit_bus[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            occ_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            fqs_pkg::CMD_ENQUEUE: begin
                                if (full) begin
                                    m_valid_reg  <= 1'b1;
                                    m_status_reg <= fqs_pkg::STAT_FULL;
                                    m_data_reg   <= '0;
                                    m_last_reg   <= 1'b1;
                                end else begin
                                    occ_reg <= occ_reg + fqs_pkg::OCC_W'(1);
                                end
                            end
                            fqs_pkg::CMD_DEQUEUE: begin
                                m_valid_reg <= 1'b1;
                                m_last_reg  <= 1'b1;
                                if (empty) begin
                                    m_status_reg <= fqs_pkg::STAT_EMPTY;
                                    m_data_reg   <= '1;
                                end else begin
                                    m_status_reg <= fqs_pkg::STAT_VALUE;
                                    m_data_reg   <= data_bus[0];
                                    occ_reg      <= occ_less_one;
                                end
                            end
                            fqs_pkg::CMD_SEARCH: begin
                                state_reg <= S_SEARCH;
                            end
                            default: begin
                                if (empty) begin
                                    m_valid_reg  <= 1'b1;
                                    m_status_reg <= fqs_pkg::STAT_EMPTY;
                                    m_data_reg   <= '1;
                                    m_last_reg   <= 1'b1;
                                end else begin
                                    cnt_reg   <= occ_less_one[fqs_pkg::CNT_W-1:0];
                                    state_reg <= S_SHOW;
                                end
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= (|hit_bus) ? fqs_pkg::STAT_FOUND
                                                   : fqs_pkg::STAT_NOT_FOUND;
                        m_data_reg   <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_SHOW: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= fqs_pkg::STAT_VALUE;
                        m_data_reg   <= data_bus[0];
                        m_last_reg   <= (cnt_reg == '0);
                        if (cnt_reg == '0) begin
                            state_reg <= S_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg - fqs_pkg::CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

endmodule

@@ tb/sv/fqs_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_tb_pkg
// scoreboard for the fifo queue with search: keeps a mirror of the queue
// and checks each result against the oldest expected one
// ----------------------------------------------------------------------------
package fqs_tb_pkg;

    import fqs_pkg::*;

    typedef struct {
        status_t                       status;
        logic signed [DATA_WIDTH-1:0] data;
        logic                          last;
    } queue_result_t;

    class queue_scoreboard;

        logic signed [DATA_WIDTH-1:0] mirror_words [QUEUE_DEPTH];
        logic [CNT_W-1:0]             head_slot;
        logic [CNT_W-1:0]             tail_slot;
        logic [OCC_W-1:0]             fill_level;
        queue_result_t                pending_results [$];

        int errors;
        int results_checked;
        int cmd_count [4];
        int full_drops;
        int search_hits;
        int peak_fill;

        function new();
            head_slot       = '0;
            tail_slot       = '0;
            fill_level      = '0;
            errors          = 0;
            results_checked = 0;
            full_drops      = 0;
            search_hits     = 0;
            peak_fill       = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
        endfunction

        function logic [CNT_W-1:0] next_slot(logic [CNT_W-1:0] p);
            return (p == CNT_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        function void add_result(status_t status, logic signed [DATA_WIDTH-1:0] data,
                                 logic last);
            queue_result_t r;
            r.status = status;
            r.data   = data;
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int occupancy();
            return int'(fill_level);
        endfunction

        // k-th stored word counted from the oldest
        function logic signed [DATA_WIDTH-1:0] word_at(int k);
            logic [CNT_W-1:0] p;
            p = head_slot;
            repeat (k) p = next_slot(p);
            return mirror_words[p];
        endfunction

        // accepted input transaction: update the mirror and queue up its results
        function void note_command(cmd_t cmd, logic signed [DATA_WIDTH-1:0] value);
            logic [CNT_W-1:0] p;
            bit               hit;
            cmd_count[cmd]++;
            case (cmd)
                CMD_ENQUEUE: begin
                    if (fill_level == OCC_W'(QUEUE_DEPTH)) begin
                        add_result(STAT_FULL, '0, 1'b1);
                        full_drops++;
                    end else begin
                        mirror_words[tail_slot] = value;
                        tail_slot  = next_slot(tail_slot);
                        fill_level = fill_level + 1'b1;
                        if (int'(fill_level) > peak_fill) peak_fill = int'(fill_level);
                    end
                end
                CMD_DEQUEUE: begin
                    if (fill_level == '0) begin
                        add_result(STAT_EMPTY, '1, 1'b1);
                    end else begin
                        add_result(STAT_VALUE, mirror_words[head_slot], 1'b1);
                        head_slot  = next_slot(head_slot);
                        fill_level = fill_level - 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    hit = 0;
                    p   = head_slot;
                    for (int n = 0; n < int'(fill_level); n++) begin
                        if (mirror_words[p] == value) hit = 1;
                        p = next_slot(p);
                    end
                    add_result(hit ? STAT_FOUND : STAT_NOT_FOUND, '0, 1'b1);
                    if (hit) search_hits++;
                end
                default: begin
                    if (fill_level == '0) begin
                        add_result(STAT_EMPTY, '1, 1'b1);
                    end else begin
                        p = head_slot;
                        for (int n = 0; n < int'(fill_level); n++) begin
                            add_result(STAT_VALUE, mirror_words[p],
                                       (n + 1 == int'(fill_level)));
                            p = next_slot(p);
                        end
                    end
                end
            endcase
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_result(logic [2:0] status, logic signed [DATA_WIDTH-1:0] data,
                                   logic last);
            queue_result_t exp_r;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d data %0d last %0d",
                       status, data, last);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            results_checked++;
            if (status !== exp_r.status) begin
                $error("status mismatch: expected %0d, got %0d", exp_r.status, status);
                errors++;
            end
            if (data !== exp_r.data) begin
                $error("data mismatch: expected %0d, got %0d", exp_r.data, data);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last mismatch: expected %0d, got %0d", exp_r.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// testbench for fifo_queue_with_search_core: directed corner cases then
// biased random command streams, with random gaps on both channels
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;
    import fqs_tb_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int ITEMS       = 460;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 20;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_command = '0;
    logic signed [DATA_WIDTH-1:0] s_value   = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    logic [2:0]                   m_status;
    logic signed [DATA_WIDTH-1:0] m_data;
    logic                         m_last;

    queue_scoreboard board = new();

    logic signed [DATA_WIDTH-1:0] edge_words [6] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
        32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa
    };

    int  items_sent  = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    int  rx_roll;
    bit  tx_steady   = 0;
    bit  rx_steady   = 0;

    fifo_queue_with_search_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_last    (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // result side: random backpressure, mostly short stalls
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_status, m_data, m_last);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // valid stays up across back-to-back transactions; lowered for a gap or while the results drain
    task automatic send(cmd_t cmd, logic signed [DATA_WIDTH-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= value;
        do @(posedge aclk); while (!s_ready);
        board.note_command(cmd, value);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    function automatic cmd_t pick_command(int mode);
        int r;
        int w_enq;
        int w_deq;
        int w_srch;
        r = $urandom_range(0, 99);
        case (mode)
            0:       begin w_enq = 65; w_deq = 15; w_srch = 12; end
            1:       begin w_enq = 20; w_deq = 55; w_srch = 15; end
            2:       begin w_enq = 40; w_deq = 35; w_srch = 15; end
            default: begin w_enq = 30; w_deq = 20; w_srch = 30; end
        endcase
        if (r < w_enq)                  return CMD_ENQUEUE;
        if (r < w_enq + w_deq)          return CMD_DEQUEUE;
        if (r < w_enq + w_deq + w_srch) return CMD_SEARCH;
        return CMD_SHOW;
    endfunction

    // mix of wide random words, a small pool that repeats, the extremes, and stored words for a search
    function automatic logic signed [DATA_WIDTH-1:0] pick_value(cmd_t cmd);
        int r;
        r = $urandom_range(0, 9);
        if (cmd == CMD_SEARCH && r >= 7 && board.occupancy() > 0)
            return board.word_at($urandom_range(0, board.occupancy() - 1));
        if (r >= 4 && r <= 6) return int'($urandom_range(0, 7)) - 4;
        if (r == 7) return edge_words[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    initial begin
        int   seg_len;
        int   mode;
        cmd_t cmd;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue cases
        send(CMD_DEQUEUE, $urandom);
        send(CMD_SHOW, $urandom);
        send(CMD_SEARCH, 32'sh0000_0000);
        // fill to the brim, extremes first, then overflow
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send(CMD_ENQUEUE, (i < 6) ? edge_words[i] : $urandom);
        send(CMD_ENQUEUE, 32'sh1234_5678);
        send(CMD_SEARCH, 32'sh7fff_ffff);
        send(CMD_SEARCH, 32'sh7fff_fffe);
        send(CMD_SHOW, $urandom);
        send(CMD_DEQUEUE, $urandom);
        send(CMD_SEARCH, 32'sh8000_0000);
        wait_drained();

        while (items_sent < ITEMS) begin
            seg_len   = $urandom_range(8, 40);
            mode      = $urandom_range(0, 3);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) wait_drained();
            for (int k = 0; k < seg_len && items_sent < ITEMS; k++) begin
                cmd = pick_command(mode);
                send(cmd, pick_value(cmd));
            end
        end

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge aclk);

        $display("sent %0d commands: %0d enqueue, %0d dequeue, %0d search, %0d show",
                 items_sent, board.cmd_count[CMD_ENQUEUE], board.cmd_count[CMD_DEQUEUE],
                 board.cmd_count[CMD_SEARCH], board.cmd_count[CMD_SHOW]);
        $display("checked %0d results, fill peaked at %0d, %0d overflow drops, %0d hits",
                 board.results_checked, board.peak_fill, board.full_drops, board.search_hits);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fqs_pkg.sv
rtl/fqs_cell.sv
rtl/fifo_queue_with_search_core.sv
tb/sv/fqs_tb_pkg.sv
tb/sv/tb.sv
